FILE: design/fcull_pkg.sv
// ============================================================================
// fcull_pkg - shared types and constants for the frustum cull test
// Plane layout, pipeline stage enables, verdict codes and data widths.
// ============================================================================
package fcull_pkg;

   localparam int NUM_PLANES  = 6;
   localparam int NUM_AXES    = 3;
   localparam int COORD_W     = 16;
   localparam int RADIUS_W    = 15;
   localparam int PROD_W      = 2 * COORD_W;      // 16x16 signed product
   localparam int SUM_W       = PROD_W + 2;       // three products plus offset
   localparam int DIST_W      = SUM_W + 1;        // distance plus or minus radius
   localparam int FRAC_SHIFT  = 14;               // Q1.14 normal scale
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int REG_IDX_W   = 3;
   localparam int REG_IDX_LSB = 3;                // 8-byte register stride

   typedef enum logic [1:0] {
      VERDICT_INSIDE     = 2'd0,
      VERDICT_INTERSECTS = 2'd1,
      VERDICT_OUTSIDE    = 2'd2
   } verdict_type;

   // one plane register: offset on top, nx at the bottom
   typedef struct packed {
      logic signed [COORD_W-1:0] d;
      logic signed [COORD_W-1:0] nz;
      logic signed [COORD_W-1:0] ny;
      logic signed [COORD_W-1:0] nx;
   } plane_type;

   // load enables for the per-plane pipeline registers
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

FILE: design/fcull_csr.sv
// ============================================================================
// fcull_csr - plane register file
// Six 64-bit plane registers behind an APB-style port, 8-byte stride.
// ============================================================================
module fcull_csr
   import fcull_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output plane_type             planes [NUM_PLANES]
);

   plane_type             planes_ff [NUM_PLANES];
   plane_type             planes_in [NUM_PLANES];
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx = paddr[REG_IDX_LSB +: REG_IDX_W];
   assign wr_en   = psel && penable && pwrite;

   // indexes past the last plane neither write nor read anything
   always_comb begin
      planes_in = planes_ff;
      prdata    = '0;
      for (int i = 0; i < NUM_PLANES; i++) begin
         if (reg_idx == REG_IDX_W'(i)) begin
            prdata = planes_ff[i];
            if (wr_en) begin
               planes_in[i] = pwdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            planes_ff[i] <= '0;
         end
      end else begin
         planes_ff <= planes_in;
      end
   end

   assign planes = planes_ff;

endmodule

FILE: design/fcull_plane.sv
// ============================================================================
// fcull_plane - three-stage distance test against one plane
// Products, min/max corner sums, offset add and sign compares.
// ============================================================================
module fcull_plane
   import fcull_pkg::*;
(
   input  logic                       clock,
   input  plane_type                  plane,
   input  stage_en_type               en,
   input  logic signed [COORD_W-1:0]  pt_a [NUM_AXES],
   input  logic signed [COORD_W-1:0]  pt_b [NUM_AXES],
   input  logic                       mode_s1,
   input  logic                       mode_s2,
   input  logic [RADIUS_W-1:0]        radius_s2,
   output logic                       out_flag,
   output logic                       cut_flag
);

   logic signed [COORD_W-1:0] norm [NUM_AXES];

   logic signed [PROD_W-1:0]  prod_a_ff [NUM_AXES];
   logic signed [PROD_W-1:0]  prod_b_ff [NUM_AXES];
   logic signed [PROD_W-1:0]  prod_a_in [NUM_AXES];
   logic signed [PROD_W-1:0]  prod_b_in [NUM_AXES];

   logic signed [SUM_W-1:0]   sum_lo_ff, sum_lo_in;
   logic signed [SUM_W-1:0]   sum_hi_ff, sum_hi_in;

   logic signed [SUM_W-1:0]   offset;
   logic signed [SUM_W-1:0]   dist_lo, dist_hi;
   logic signed [DIST_W-1:0]  dist_ext, r_ext, dist_plus_r, dist_minus_r;
   logic                      out_flag_ff, out_flag_in;
   logic                      cut_flag_ff, cut_flag_in;

   assign norm[0] = plane.nx;
   assign norm[1] = plane.ny;
   assign norm[2] = plane.nz;

   // stage 1: normal times both candidate coordinates on each axis
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         prod_a_in[k] = norm[k] * pt_a[k];
         prod_b_in[k] = norm[k] * pt_b[k];
      end
   end

   // stage 2: the nearest and farthest corners pick the smaller and larger
   // term per axis; a sphere only uses its center
   always_comb begin
      logic signed [PROD_W-1:0] lo, hi;
      sum_lo_in = '0;
      sum_hi_in = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
         if (mode_s1) begin
            lo = prod_a_ff[k];
            hi = prod_a_ff[k];
         end else if (prod_a_ff[k] < prod_b_ff[k]) begin
            lo = prod_a_ff[k];
            hi = prod_b_ff[k];
         end else begin
            lo = prod_b_ff[k];
            hi = prod_a_ff[k];
         end
         sum_lo_in = sum_lo_in + SUM_W'(lo);
         sum_hi_in = sum_hi_in + SUM_W'(hi);
      end
   end

   // stage 3: add the scaled offset and classify by sign
   assign offset   = {{(SUM_W-COORD_W-FRAC_SHIFT){plane.d[COORD_W-1]}}, plane.d,
                      {FRAC_SHIFT{1'b0}}};
   assign dist_lo  = sum_lo_ff + offset;
   assign dist_hi  = sum_hi_ff + offset;
   assign dist_ext = DIST_W'(dist_lo);
   assign r_ext    = {{(DIST_W-RADIUS_W-FRAC_SHIFT){1'b0}}, radius_s2,
                      {FRAC_SHIFT{1'b0}}};
   assign dist_plus_r  = dist_ext + r_ext;
   assign dist_minus_r = dist_ext - r_ext;

   always_comb begin
      if (mode_s2) begin
         out_flag_in = dist_plus_r[DIST_W-1];
         cut_flag_in = dist_minus_r[DIST_W-1];
      end else begin
         out_flag_in = dist_hi[SUM_W-1];   // no corner on the inner side
         cut_flag_in = dist_lo[SUM_W-1];   // some corner on the outer side
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
      if (en.s2) begin
         sum_lo_ff <= sum_lo_in;
         sum_hi_ff <= sum_hi_in;
      end
      if (en.s3) begin
         out_flag_ff <= out_flag_in;
         cut_flag_ff <= cut_flag_in;
      end
   end

   assign out_flag = out_flag_ff;
   assign cut_flag = cut_flag_ff;

endmodule

FILE: design/frustum_cull_test.sv
// ============================================================================
// frustum_cull_test - box / sphere versus six-plane frustum classifier
// Four-stage pipeline: products, corner sums, plane compares, verdict.
// ============================================================================
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------
//  req      | in        | req_valid / req_ready     | mode, ax..bz, radius
//  rsp      | out       | rsp_valid / rsp_ready     | verdict
//  csr      | in        | psel / penable / pready   | paddr, pwdata, prdata
//
//  One beat per cycle sustained while rsp_ready stays high; a beat's verdict
//  passes the product, sum and compare registers and the output register
//  before it shows on rsp. The stage split is multiply, three-term sum,
//  offset add with sign test, and the six-plane reduction.
//  Each stage holds a valid bit; a stage loads when it is empty or its
//  occupant moves on, so a stalled rsp fills the pipe before req_ready drops.
//  Synchronous reset clears the valid bits and all planes (boxes and
//  zero-radius spheres then read as inside, other spheres as intersecting).
//
module frustum_cull_test
   import fcull_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic signed [COORD_W-1:0]   req_ax,
   input  logic signed [COORD_W-1:0]   req_ay,
   input  logic signed [COORD_W-1:0]   req_az,
   input  logic signed [COORD_W-1:0]   req_bx,
   input  logic signed [COORD_W-1:0]   req_by,
   input  logic signed [COORD_W-1:0]   req_bz,
   input  logic [RADIUS_W-1:0]         req_radius,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_verdict,

   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [CSR_ADDR_W-1:0]       paddr,
   input  logic [CSR_DATA_W-1:0]       pwdata,
   output logic [CSR_DATA_W-1:0]       prdata,
   output logic                        pready
);

   plane_type planes [NUM_PLANES];

   // stage valid bits; v4 is the output register
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   stage_en_type en;

   // side data that travels with a beat
   logic                  mode_s1_ff, mode_s2_ff;
   logic [RADIUS_W-1:0]   radius_s1_ff, radius_s2_ff;
   verdict_type           verdict_ff, verdict_in;

   logic signed [COORD_W-1:0] pt_a [NUM_AXES];
   logic signed [COORD_W-1:0] pt_b [NUM_AXES];
   logic [NUM_PLANES-1:0]     out_flags, cut_flags;

   // --------------------------------------------------------------------
   // configuration
   // --------------------------------------------------------------------
   fcull_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .planes  (planes)
   );

   assign pready = 1'b1;

   // --------------------------------------------------------------------
   // flow control: ready ripples back from the output register
   // --------------------------------------------------------------------
   assign rdy4 = !v4_ff || rsp_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_ready = rdy1;
   assign en.s1     = req_valid && rdy1;
   assign en.s2     = v1_ff && rdy2;
   assign en.s3     = v2_ff && rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         mode_s1_ff   <= req_mode;
         radius_s1_ff <= req_radius;
      end
      if (en.s2) begin
         mode_s2_ff   <= mode_s1_ff;
         radius_s2_ff <= radius_s1_ff;
      end
      if (v3_ff && rdy4) begin
         verdict_ff <= verdict_in;
      end
   end

   // --------------------------------------------------------------------
   // per-plane datapath
   // --------------------------------------------------------------------
   assign pt_a[0] = req_ax;
   assign pt_a[1] = req_ay;
   assign pt_a[2] = req_az;
   assign pt_b[0] = req_bx;
   assign pt_b[1] = req_by;
   assign pt_b[2] = req_bz;

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      fcull_plane u_plane (
         .clock     (clock),
         .plane     (planes[p]),
         .en        (en),
         .pt_a      (pt_a),
         .pt_b      (pt_b),
         .mode_s1   (mode_s1_ff),
         .mode_s2   (mode_s2_ff),
         .radius_s2 (radius_s2_ff),
         .out_flag  (out_flags[p]),
         .cut_flag  (cut_flags[p])
      );
   end

   // --------------------------------------------------------------------
   // stage 4: any plane fully outside wins over any plane cutting
   // --------------------------------------------------------------------
   always_comb begin
      priority if (|out_flags) begin
         verdict_in = VERDICT_OUTSIDE;
      end else if (|cut_flags) begin
         verdict_in = VERDICT_INTERSECTS;
      end else begin
         verdict_in = VERDICT_INSIDE;
      end
   end

   assign rsp_valid   = v4_ff;
   assign rsp_verdict = verdict_ff;

endmodule

FILE: design/fcull_checker.sv
// ============================================================================
// fcull_checker - port-level checks for frustum_cull_test
// Output hold under stall, legal verdicts, flow control and reset behavior.
// ============================================================================
module fcull_checker
   import fcull_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_mode,
   input  logic signed [COORD_W-1:0]   req_ax,
   input  logic signed [COORD_W-1:0]   req_ay,
   input  logic signed [COORD_W-1:0]   req_az,
   input  logic signed [COORD_W-1:0]   req_bx,
   input  logic signed [COORD_W-1:0]   req_by,
   input  logic signed [COORD_W-1:0]   req_bz,
   input  logic [RADIUS_W-1:0]         req_radius,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [1:0]                  rsp_verdict,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [CSR_ADDR_W-1:0]       paddr,
   input  logic [CSR_DATA_W-1:0]       pwdata,
   input  logic [CSR_DATA_W-1:0]       prdata,
   input  logic                        pready
);

   // a stalled result beat holds its verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict))
      else $error("rsp beat changed while stalled");

   // only the three defined verdict codes are ever shown
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_INSIDE ||
                     rsp_verdict == VERDICT_INTERSECTS ||
                     rsp_verdict == VERDICT_OUTSIDE))
      else $error("undefined verdict code");

   // with the output register empty nothing can block the input
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with an empty output");

   // reset leaves no result beat behind
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // the register port never inserts wait states
   a_no_wait: assert property (@(posedge clock) disable iff (reset)
      psel && penable |-> pready)
      else $error("pready low during access");

endmodule

bind frustum_cull_test fcull_checker u_fcull_checker (.*);

FILE: bench/tb_frustum_cull_test.sv
// ============================================================================
// tb_frustum_cull_test - self-checking bench for the frustum cull classifier
// Loads plane sets over the CSR port, streams boxes and spheres through the
// req channel in random bursts and checks every rsp verdict against a
// behavioral classifier kept in step with the programmed planes.
// ============================================================================
`timescale 1ns / 100ps

module tb_frustum_cull_test;
   import fcull_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;   // quiet cycles before giving up
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 20;     // pipe is four deep, keep margin
   localparam logic signed [COORD_W-1:0] UNIT_NORMAL = 16'sd16384;   // 1.0 in Q1.14
   localparam logic signed [COORD_W-1:0] COORD_MAX   = 16'sh7fff;
   localparam logic signed [COORD_W-1:0] COORD_MIN   = 16'sh8000;

   // CSR map: one 64-bit plane per 8-byte slot, two unused slots at the top
   typedef enum int unsigned {
      REG_PLANE_TOP, REG_PLANE_BOTTOM, REG_PLANE_LEFT, REG_PLANE_RIGHT,
      REG_PLANE_NEAR, REG_PLANE_FAR, REG_SPARE_A, REG_SPARE_B
   } csr_index_type;

   typedef enum logic {
      SHAPE_BOX    = 1'b0,
      SHAPE_SPHERE = 1'b1
   } shape_type;

   typedef struct {
      shape_type                 mode;
      logic signed [COORD_W-1:0] ax, ay, az;
      logic signed [COORD_W-1:0] bx, by, bz;
      logic [RADIUS_W-1:0]       radius;
   } cull_obj_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_mode = 1'b0;
   logic signed [COORD_W-1:0] req_ax = '0, req_ay = '0, req_az = '0;
   logic signed [COORD_W-1:0] req_bx = '0, req_by = '0, req_bz = '0;
   logic [RADIUS_W-1:0]       req_radius = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_verdict;
   logic                      psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr = '0;
   logic [CSR_DATA_W-1:0]     pwdata = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   // bench-side copy of the plane registers, updated on each CSR write to a plane slot
   plane_type    plane_regs [NUM_PLANES] = '{default: '0};
   cull_obj_type pending_objects [$];
   verdict_type  expected_verdicts [$];
   int           error_count = 0;

   frustum_cull_test u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_ax      (req_ax),
      .req_ay      (req_ay),
      .req_az      (req_az),
      .req_bx      (req_bx),
      .req_by      (req_by),
      .req_bz      (req_bz),
      .req_radius  (req_radius),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------------
   // Classifier
   // ------------------------------------------------------------------------

   // Exact signed distance, 18 fraction bits: n . p + d * 2^14.
   // Worst case is about 3.8e9, so 64-bit math never wraps.
   function automatic longint plane_dist(input plane_type pl,
                                         input longint px, py, pz);
      return pl.nx * px + pl.ny * py + pl.nz * pz + (longint'(pl.d) <<< FRAC_SHIFT);
   endfunction

   function automatic verdict_type classify_object(input cull_obj_type obj);
      verdict_type verdict;
      longint      dist_val, r;
      bit          any_in, any_out;
      verdict = VERDICT_INSIDE;
      r = longint'(obj.radius) <<< FRAC_SHIFT;
      for (int p = 0; p < NUM_PLANES; p++) begin
         if (obj.mode == SHAPE_BOX) begin
            any_in  = 1'b0;
            any_out = 1'b0;
            // corners taken as given: an inverted box is not reordered
            for (int c = 0; c < 8; c++) begin
               dist_val = plane_dist(plane_regs[p], c[0] ? obj.bx : obj.ax,
                                     c[1] ? obj.by : obj.ay, c[2] ? obj.bz : obj.az);
               if (dist_val < 0) any_out = 1'b1;
               else              any_in  = 1'b1;
            end
            // fully behind any plane wins, even after an earlier straddle
            if (!any_in) return VERDICT_OUTSIDE;
            if (any_out) verdict = VERDICT_INTERSECTS;
         end else begin
            dist_val = plane_dist(plane_regs[p], obj.ax, obj.ay, obj.az);
            if (dist_val < -r) return VERDICT_OUTSIDE;
            if (dist_val < r)  verdict = VERDICT_INTERSECTS;
         end
      end
      return verdict;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // unused fields get random junk so the block is seen to ignore them
   function automatic cull_obj_type make_box(input int ax, ay, az, bx, by, bz);
      cull_obj_type o;
      o.mode   = SHAPE_BOX;
      o.ax     = 16'(ax);  o.ay = 16'(ay);  o.az = 16'(az);
      o.bx     = 16'(bx);  o.by = 16'(by);  o.bz = 16'(bz);
      o.radius = 15'($urandom);
      return o;
   endfunction

   function automatic cull_obj_type make_sphere(input int cx, cy, cz, r);
      cull_obj_type o;
      o.mode   = SHAPE_SPHERE;
      o.ax     = 16'(cx);  o.ay = 16'(cy);  o.az = 16'(cz);
      o.bx     = 16'($urandom);
      o.by     = 16'($urandom);
      o.bz     = 16'($urandom);
      o.radius = 15'(r);
      return o;
   endfunction

   function automatic logic signed [COORD_W-1:0] coord_near(input int span);
      return 16'($urandom_range(2 * span)) - 16'(span);
   endfunction

   // span 0: every field uniform over its full range.
   // Otherwise mostly well-formed objects scaled to the frustum, a few
   // inverted boxes, and one in eight left as full-range noise.
   function automatic cull_obj_type make_random_object(input int span);
      cull_obj_type o;
      int           ext;
      o.mode   = shape_type'($urandom_range(1));
      o.ax     = 16'($urandom);  o.ay = 16'($urandom);  o.az = 16'($urandom);
      o.bx     = 16'($urandom);  o.by = 16'($urandom);  o.bz = 16'($urandom);
      o.radius = 15'($urandom);
      if (span != 0 && $urandom_range(7) != 0) begin
         ext  = span / 2 + 1;
         o.ax = coord_near(span);
         o.ay = coord_near(span);
         o.az = coord_near(span);
         o.bx = o.ax + 16'($urandom_range(ext));
         o.by = o.ay + 16'($urandom_range(ext));
         o.bz = o.az + 16'($urandom_range(ext));
         if ($urandom_range(15) == 0) o.bx = o.ax - 16'($urandom_range(1, ext));
         o.radius = 15'($urandom_range(ext));
      end
      return o;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pack_plane(input int nx, ny, nz, d);
      return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
   endfunction

   // setup then access; the write lands on the access edge. Returns at negedge.
   task automatic write_csr(input csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << REG_IDX_LSB;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx <= REG_PLANE_FAR) plane_regs[idx] = plane_type'(value);
      @(negedge clock);
   endtask

   // cube of half-size w (Q12.4) centered on the origin, normals pointing in
   task automatic load_cube_frustum(input int w);
      write_csr(REG_PLANE_TOP,    pack_plane(0, -UNIT_NORMAL, 0, w));
      write_csr(REG_PLANE_BOTTOM, pack_plane(0, UNIT_NORMAL, 0, w));
      write_csr(REG_PLANE_LEFT,   pack_plane(UNIT_NORMAL, 0, 0, w));
      write_csr(REG_PLANE_RIGHT,  pack_plane(-UNIT_NORMAL, 0, 0, w));
      write_csr(REG_PLANE_NEAR,   pack_plane(0, 0, UNIT_NORMAL, w));
      write_csr(REG_PLANE_FAR,    pack_plane(0, 0, -UNIT_NORMAL, w));
   endtask

   task automatic load_uniform_planes(input logic [CSR_DATA_W-1:0] value);
      for (int p = 0; p < NUM_PLANES; p++) write_csr(csr_index_type'(p), value);
   endtask

   // box and sphere at the corners of the coordinate range
   task automatic push_range_corners();
      pending_objects.push_back(make_box(COORD_MIN, COORD_MIN, COORD_MIN,
                                         COORD_MAX, COORD_MAX, COORD_MAX));
      pending_objects.push_back(make_box(COORD_MAX, COORD_MAX, COORD_MAX,
                                         COORD_MIN, COORD_MIN, COORD_MIN));
      pending_objects.push_back(make_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 32767));
      pending_objects.push_back(make_sphere(COORD_MAX, COORD_MAX, COORD_MAX, 0));
   endtask

   // queues random objects, then waits for every verdict to come back
   task automatic run_objects(input int count, input int span);
      for (int i = 0; i < count; i++) pending_objects.push_back(make_random_object(span));
      while (pending_objects.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // req driver: bursts of random length separated by random gaps
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : req_driver
      cull_obj_type obj;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || req_ready) begin
         // slot is free: any held beat is taken at this edge
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_objects.size() != 0) begin
            obj = pending_objects.pop_front();
            req_valid  <= 1'b1;
            req_mode   <= obj.mode;
            req_ax     <= obj.ax;
            req_ay     <= obj.ay;
            req_az     <= obj.az;
            req_bx     <= obj.bx;
            req_by     <= obj.by;
            req_bz     <= obj.bz;
            req_radius <= obj.radius;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 32);
               // a third of the bursts run straight into the next one
               gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // rsp backpressure: a rotating 16-bit ready pattern, reloaded whenever the
   // 6-bit age counter wraps; never all zeros, so every stall ends
   // ------------------------------------------------------------------------
   logic [15:0] ready_pattern = 16'hffff;
   logic [5:0]  pattern_age   = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready     <= 1'b0;
         ready_pattern <= 16'hffff;
         pattern_age   <= '0;
      end else begin
         pattern_age <= pattern_age + 1'b1;
         if (pattern_age == '1) begin
            case ($urandom_range(3))
               0: ready_pattern <= 16'hffff;
               1: ready_pattern <= 16'h8000;
               default: ready_pattern <= 16'($urandom) | 16'h0001;
            endcase
         end else begin
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
         end
         rsp_ready <= ready_pattern[15];
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: rsp beats are checked before the req beat of the same edge is
   // predicted, so a spurious verdict can never pair with a fresh entry
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : verdict_monitor
      cull_obj_type seen;
      verdict_type  want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected rsp beat: verdict %0d", rsp_verdict);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_verdict !== want) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("verdict mismatch: expected %0d (%s) got %0d",
                              want, want.name(), rsp_verdict);
               end
            end
         end
         if (req_valid && req_ready) begin
            seen.mode   = shape_type'(req_mode);
            seen.ax     = req_ax;
            seen.ay     = req_ay;
            seen.az     = req_az;
            seen.bx     = req_bx;
            seen.by     = req_by;
            seen.bz     = req_bz;
            seen.radius = req_radius;
            expected_verdicts.push_back(classify_object(seen));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: any req or rsp beat or CSR write restarts the count
   // ------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pwrite && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // planes still at reset: all distances zero, so boxes are inside and spheres of nonzero radius intersect
      push_range_corners();
      run_objects(40, 0);

      // cube frustum, half-size 1000: boundary cases on each side
      load_cube_frustum(1000);
      pending_objects.push_back(make_box(-10, -10, -10, 10, 10, 10));           // inside
      pending_objects.push_back(make_box(-1000, 0, 0, 0, 10, 10));              // on plane
      pending_objects.push_back(make_box(-1001, 0, 0, 0, 10, 10));              // straddles
      pending_objects.push_back(make_box(-2000, 0, 0, -1001, 10, 10));          // behind left
      // straddles bottom before lying fully behind left: outside wins
      pending_objects.push_back(make_box(-2000, -2000, 0, -1500, 0, 10));
      pending_objects.push_back(make_box(10, 10, 10, -10, -10, -10));           // inverted
      pending_objects.push_back(make_box(500, 500, 500, -2000, 0, 0));          // inverted, straddles
      pending_objects.push_back(make_box(1000, 1000, 1000, 1000, 1000, 1000));  // point at corner
      pending_objects.push_back(make_sphere(0, 0, 0, 0));
      pending_objects.push_back(make_sphere(0, 0, 0, 32767));
      pending_objects.push_back(make_sphere(-1051, 0, 0, 50));   // one past touching
      pending_objects.push_back(make_sphere(-1050, 0, 0, 50));   // touches from outside
      pending_objects.push_back(make_sphere(-950, 0, 0, 50));    // touches from inside
      pending_objects.push_back(make_sphere(-951, 0, 0, 50));    // just crosses
      push_range_corners();
      run_objects(400, 1600);

      // oblique planes with random normals and offsets, growing scale
      for (int k = 0; k < 4; k++) begin
         for (int p = 0; p < NUM_PLANES; p++)
            write_csr(csr_index_type'(p),
                      pack_plane($urandom_range(2 * UNIT_NORMAL) - UNIT_NORMAL,
                                 $urandom_range(2 * UNIT_NORMAL) - UNIT_NORMAL,
                                 $urandom_range(2 * UNIT_NORMAL) - UNIT_NORMAL,
                                 (k == 3) ? int'($urandom) : $urandom_range(1000) - 500));
         run_objects(140, (k == 3) ? 0 : 300 << (2 * k));
      end

      // largest magnitudes: products and sums at full width
      load_uniform_planes({COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
      push_range_corners();
      run_objects(100, 0);
      load_uniform_planes({COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN});
      push_range_corners();
      run_objects(100, 0);

      // widest cube, then writes to the unused slots that must change nothing
      load_cube_frustum(COORD_MAX);
      write_csr(REG_SPARE_A, {$urandom, $urandom});
      write_csr(REG_SPARE_B, {$urandom, $urandom});
      run_objects(150, 0);

      // degenerate cube of zero size, only the origin is inside
      load_cube_frustum(0);
      write_csr(REG_SPARE_A, '1);
      pending_objects.push_back(make_box(0, 0, 0, 0, 0, 0));
      run_objects(150, 40);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
